FILE: rtl/qftv_pkg.sv
// shared types and constants for the shortest-arc quaternion core
package qftv_pkg;

  // field formats
  localparam int IN_W     = 16;
  localparam int OUT_FRAC = 14;
  localparam int OUT_W    = OUT_FRAC + 2;

  // integer square root datapath
  localparam int RAD_W  = 64;
  localparam int ROOT_W = RAD_W / 2;

  // opposite-vector threshold, as a left shift of the real part
  localparam int OPP_SHIFT = 20;

  // component magnitudes are brought below 2^NORM_W before squaring
  localparam int NORM_W = 30;

  // quotient bits of the normalizing divide
  localparam int QUO_W = OUT_FRAC + 1;

  typedef struct packed {
    logic signed [IN_W-1:0] u_x;
    logic signed [IN_W-1:0] u_y;
    logic signed [IN_W-1:0] u_z;
    logic signed [IN_W-1:0] v_x;
    logic signed [IN_W-1:0] v_y;
    logic signed [IN_W-1:0] v_z;
  } qftv_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] q_real;
    logic signed [OUT_W-1:0] q_i;
    logic signed [OUT_W-1:0] q_j;
    logic signed [OUT_W-1:0] q_k;
    logic                    degenerate;
  } qftv_out_t;

endpackage

FILE: rtl/qftv_isqrt.sv
// pipelined integer square root, one result bit per register stage
module qftv_isqrt import qftv_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0] rem_q [ROOT_W];
  logic [RAD_W-1:0] acc_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
    logic [RAD_W-1:0] rem_in;
    logic [RAD_W-1:0] acc_in;
    logic [RAD_W-1:0] trial;

    // stage input: the radicand for the first step, the previous stage otherwise
    if (k == 0) begin : g_first
      assign rem_in = radicand;
      assign acc_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign acc_in = acc_q[k-1];
    end

    assign trial = acc_in + BIT;

    // one restoring step
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          acc_q[k] <= (acc_in >> 1) + BIT;
        end else begin
          rem_q[k] <= rem_in;
          acc_q[k] <= acc_in >> 1;
        end
      end
    end
  end

  assign root = acc_q[ROOT_W-1][ROOT_W-1:0];

endmodule

FILE: rtl/quaternion_from_two_vectors_core.sv
// top level: shortest-arc rotation quaternion from two vectors
//
// Takes two Q8.8 vectors u and v per beat and returns the unit quaternion (Q2.14)
// that turns u onto v; a zero input vector gives the identity with degenerate set,
// and opposite vectors get a real part of zero about an axis orthogonal to u.
// The core is a fully pipelined datapath: one beat can enter every cycle while
// the skid entry is free, through two 32-stage square root pipelines (|u||v| and
// the quaternion norm), a 15-stage restoring divider for the normalization and ten
// arithmetic and register stages around them. A two-entry output stage (result
// register and skid entry) lets the pipeline keep taking beats after the result
// side stops, until a result waits in the skid entry; that stalls every stage.
module quaternion_from_two_vectors_core import qftv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  qftv_in_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output qftv_out_t result
);

  localparam int PROD_W = 2 * IN_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int UU_W   = PROD_W;
  localparam int CR_W   = PROD_W + 1;
  localparam int R_W    = SUM_W;
  localparam int Q_W    = R_W + 1;
  localparam int MAG_W  = R_W;
  localparam int SH_W   = 3;
  localparam int SQ_W   = 2 * NORM_W;
  localparam int NUM_W  = NORM_W + OUT_FRAC + 1;
  localparam int DIV_W  = ROOT_W + QUO_W;

  typedef struct packed {
    logic signed [IN_W-1:0]  ux;
    logic signed [IN_W-1:0]  uy;
    logic signed [IN_W-1:0]  uz;
    logic signed [SUM_W-1:0] d;
    logic signed [CR_W-1:0]  cx;
    logic signed [CR_W-1:0]  cy;
    logic signed [CR_W-1:0]  cz;
    logic                    degen;
  } sb1_t;

  typedef struct packed {
    logic [3:0][NORM_W-1:0] mg;
    logic [3:0]             neg;
    logic                   degen;
  } sb2_t;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [Q_W-1:0] v);
    mag_of = v[Q_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  logic en;
  logic skid_valid;
  qftv_out_t skid;

  // whole pipeline moves together while the skid entry is free
  assign en         = !skid_valid;
  assign item_ready = en;

  // stage 1: all component products
  logic v1;
  logic signed [IN_W-1:0]   ux1, uy1, uz1;
  logic signed [PROD_W-1:0] squ1 [3];
  logic signed [PROD_W-1:0] sqv1 [3];
  logic signed [PROD_W-1:0] dot1 [3];
  logic signed [PROD_W-1:0] cr1 [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux1     <= item.u_x;
      uy1     <= item.u_y;
      uz1     <= item.u_z;
      squ1[0] <= PROD_W'(item.u_x) * PROD_W'(item.u_x);
      squ1[1] <= PROD_W'(item.u_y) * PROD_W'(item.u_y);
      squ1[2] <= PROD_W'(item.u_z) * PROD_W'(item.u_z);
      sqv1[0] <= PROD_W'(item.v_x) * PROD_W'(item.v_x);
      sqv1[1] <= PROD_W'(item.v_y) * PROD_W'(item.v_y);
      sqv1[2] <= PROD_W'(item.v_z) * PROD_W'(item.v_z);
      dot1[0] <= PROD_W'(item.u_x) * PROD_W'(item.v_x);
      dot1[1] <= PROD_W'(item.u_y) * PROD_W'(item.v_y);
      dot1[2] <= PROD_W'(item.u_z) * PROD_W'(item.v_z);
      cr1[0]  <= PROD_W'(item.u_y) * PROD_W'(item.v_z);
      cr1[1]  <= PROD_W'(item.u_z) * PROD_W'(item.v_y);
      cr1[2]  <= PROD_W'(item.u_z) * PROD_W'(item.v_x);
      cr1[3]  <= PROD_W'(item.u_x) * PROD_W'(item.v_z);
      cr1[4]  <= PROD_W'(item.u_x) * PROD_W'(item.v_y);
      cr1[5]  <= PROD_W'(item.u_y) * PROD_W'(item.v_x);
    end
  end

  // stage 2: squared lengths, dot and cross product
  logic v2;
  logic signed [IN_W-1:0]  ux2, uy2, uz2;
  logic [UU_W-1:0]         uu2, vv2;
  logic signed [SUM_W-1:0] d2;
  logic signed [CR_W-1:0]  cx2, cy2, cz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux2 <= ux1;
      uy2 <= uy1;
      uz2 <= uz1;
      uu2 <= UU_W'(SUM_W'(squ1[0]) + SUM_W'(squ1[1]) + SUM_W'(squ1[2]));
      vv2 <= UU_W'(SUM_W'(sqv1[0]) + SUM_W'(sqv1[1]) + SUM_W'(sqv1[2]));
      d2  <= SUM_W'(dot1[0]) + SUM_W'(dot1[1]) + SUM_W'(dot1[2]);
      cx2 <= CR_W'(cr1[0]) - CR_W'(cr1[1]);
      cy2 <= CR_W'(cr1[2]) - CR_W'(cr1[3]);
      cz2 <= CR_W'(cr1[4]) - CR_W'(cr1[5]);
    end
  end

  // stage 3: |u|^2 |v|^2 and the zero-vector flag
  logic v3;
  logic [RAD_W-1:0] prod3;
  sb1_t sb3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod3     <= RAD_W'(uu2) * RAD_W'(vv2);
      sb3.ux    <= ux2;
      sb3.uy    <= uy2;
      sb3.uz    <= uz2;
      sb3.d     <= d2;
      sb3.cx    <= cx2;
      sb3.cy    <= cy2;
      sb3.cz    <= cz2;
      sb3.degen <= (uu2 == '0) || (vv2 == '0);
    end
  end

  // first root: n = floor(|u||v|), side data delayed alongside
  logic [ROOT_W-1:0] root1;
  sb1_t              sb1_q [ROOT_W];
  logic [ROOT_W-1:0] vl1;

  qftv_isqrt u_root_len (
    .clk      (clk),
    .en       (en),
    .radicand (prod3),
    .root     (root1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vl1 <= '0;
    end else if (en) begin
      vl1 <= {vl1[ROOT_W-2:0], v3};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb1_q[0] <= sb3;
      for (int k = 1; k < ROOT_W; k++) begin
        sb1_q[k] <= sb1_q[k-1];
      end
    end
  end

  // stage 4: real part r = n + u.v, clamped at zero
  logic v4;
  logic [R_W-1:0]    r4;
  logic [ROOT_W-1:0] n4;
  sb1_t              sb4;
  logic signed [R_W:0] rsum;

  assign rsum = $signed({{(R_W + 1 - ROOT_W){1'b0}}, root1}) + (R_W + 1)'(sb1_q[ROOT_W-1].d);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= vl1[ROOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r4  <= rsum[R_W] ? '0 : rsum[R_W-1:0];
      n4  <= root1;
      sb4 <= sb1_q[ROOT_W-1];
    end
  end

  // stage 5: opposite test, pick the raw quaternion, take magnitudes
  logic v5;
  logic [3:0][MAG_W-1:0] mg5;
  logic [3:0]            neg5;
  logic                  degen5;
  logic                  opp;
  logic                  x_wide;
  logic signed [Q_W-1:0] qs [4];

  assign opp    = {r4, {OPP_SHIFT{1'b0}}} < (R_W + OPP_SHIFT)'(n4);
  assign x_wide = mag_of(Q_W'(sb4.ux)) > mag_of(Q_W'(sb4.uz));

  always_comb begin
    if (opp) begin
      qs[0] = '0;
      if (x_wide) begin
        qs[1] = -Q_W'(sb4.uy);
        qs[2] = Q_W'(sb4.ux);
        qs[3] = '0;
      end else begin
        qs[1] = '0;
        qs[2] = -Q_W'(sb4.uz);
        qs[3] = Q_W'(sb4.uy);
      end
    end else begin
      qs[0] = $signed({1'b0, r4});
      qs[1] = Q_W'(sb4.cx);
      qs[2] = Q_W'(sb4.cy);
      qs[3] = Q_W'(sb4.cz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        mg5[i]  <= mag_of(qs[i]);
        neg5[i] <= qs[i][Q_W-1];
      end
      degen5 <= sb4.degen;
    end
  end

  // stage 6: common right shift so every magnitude fits NORM_W bits
  logic v6;
  logic [3:0][NORM_W-1:0] mg6;
  logic [3:0]             neg6;
  logic                   degen6;
  logic [MAG_W-1:0]       orv;
  logic [SH_W-1:0]        sh;

  always_comb begin
    orv = mg5[0] | mg5[1] | mg5[2] | mg5[3];
    sh  = '0;
    for (int b = NORM_W; b < MAG_W; b++) begin
      if (orv[b]) begin
        sh = SH_W'(b - NORM_W + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        mg6[i] <= NORM_W'(mg5[i] >> sh);
      end
      neg6   <= neg5;
      degen6 <= degen5;
    end
  end

  // stage 7: squares
  logic v7;
  logic [3:0][SQ_W-1:0] sq7;
  sb2_t                 sb7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq7[i] <= SQ_W'(mg6[i]) * SQ_W'(mg6[i]);
      end
      sb7.mg    <= mg6;
      sb7.neg   <= neg6;
      sb7.degen <= degen6;
    end
  end

  // stage 8: sum of squares
  logic v8;
  logic [RAD_W-1:0] sum8;
  sb2_t             sb8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum8 <= RAD_W'(sq7[0]) + RAD_W'(sq7[1]) + RAD_W'(sq7[2]) + RAD_W'(sq7[3]);
      sb8  <= sb7;
    end
  end

  // second root: quaternion norm m
  logic [ROOT_W-1:0] root2;
  sb2_t              sb2_q [ROOT_W];
  logic [ROOT_W-1:0] vl2;

  qftv_isqrt u_root_norm (
    .clk      (clk),
    .en       (en),
    .radicand (sum8),
    .root     (root2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vl2 <= '0;
    end else if (en) begin
      vl2 <= {vl2[ROOT_W-2:0], v8};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb2_q[0] <= sb8;
      for (int k = 1; k < ROOT_W; k++) begin
        sb2_q[k] <= sb2_q[k-1];
      end
    end
  end

  // stage 9: rounded dividends and divisor
  logic v9;
  logic [3:0][NUM_W-1:0] num9;
  logic [ROOT_W-1:0]     den9;
  logic [3:0]            neg9;
  logic                  degen9;
  logic [ROOT_W-1:0]     m_safe;

  assign m_safe = (root2 == '0) ? ROOT_W'(1) : root2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= vl2[ROOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        num9[i] <= NUM_W'({sb2_q[ROOT_W-1].mg[i], {OUT_FRAC{1'b0}}}) + NUM_W'(m_safe >> 1);
      end
      den9   <= m_safe;
      neg9   <= sb2_q[ROOT_W-1].neg;
      degen9 <= sb2_q[ROOT_W-1].degen;
    end
  end

  // restoring divider, one quotient bit per stage on all four lanes
  logic [3:0][NUM_W-1:0] rem_q [QUO_W];
  logic [3:0][QUO_W-1:0] quo_q [QUO_W];
  logic [ROOT_W-1:0]     den_q [QUO_W];
  logic [3:0]            neg_q [QUO_W];
  logic [QUO_W-1:0]      dgn_q;
  logic [QUO_W-1:0]      dv_q;

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    localparam int B = QUO_W - 1 - k;
    logic [3:0][NUM_W-1:0] rem_in;
    logic [3:0][QUO_W-1:0] quo_in;
    logic [ROOT_W-1:0]     den_in;
    logic [3:0]            neg_in;
    logic                  dgn_in;
    logic                  v_in;
    logic [DIV_W-1:0]      trial;

    if (k == 0) begin : g_first
      assign rem_in = num9;
      assign quo_in = '0;
      assign den_in = den9;
      assign neg_in = neg9;
      assign dgn_in = degen9;
      assign v_in   = v9;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign neg_in = neg_q[k-1];
      assign dgn_in = dgn_q[k-1];
      assign v_in   = dv_q[k-1];
    end

    assign trial = DIV_W'(den_in) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_q[k] <= 1'b0;
      end else if (en) begin
        dv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 4; i++) begin
          if (DIV_W'(rem_in[i]) >= trial) begin
            rem_q[k][i] <= NUM_W'(DIV_W'(rem_in[i]) - trial);
            quo_q[k][i] <= quo_in[i] | (QUO_W'(1) << B);
          end else begin
            rem_q[k][i] <= rem_in[i];
            quo_q[k][i] <= quo_in[i];
          end
        end
        den_q[k] <= den_in;
        neg_q[k] <= neg_in;
        dgn_q[k] <= dgn_in;
      end
    end
  end

  // final beat: signs back on, identity for a zero vector
  logic      fin_valid;
  qftv_out_t fin;
  logic signed [OUT_W-1:0] sv [4];

  assign fin_valid = dv_q[QUO_W-1];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sv[i] = neg_q[QUO_W-1][i] ? -OUT_W'(quo_q[QUO_W-1][i]) : OUT_W'(quo_q[QUO_W-1][i]);
    end
    if (dgn_q[QUO_W-1]) begin
      fin.q_real     = OUT_W'(1) << OUT_FRAC;
      fin.q_i        = '0;
      fin.q_j        = '0;
      fin.q_k        = '0;
      fin.degenerate = 1'b1;
    end else begin
      fin.q_real     = sv[0];
      fin.q_i        = sv[1];
      fin.q_j        = sv[2];
      fin.q_k        = sv[3];
      fin.degenerate = 1'b0;
    end
  end

  // output register with one skid entry
  logic out_free;
  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= fin_valid;
      end
    end else if (en && fin_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        result <= skid;
      end else begin
        result <= fin;
      end
    end else if (en && fin_valid) begin
      skid <= fin;
    end
  end

endmodule

FILE: tb/quaternion_from_two_vectors_core_checker.sv
// checker: predicts each quaternion from the accepted vector pairs and compares results
`timescale 1ns / 1ps
module quaternion_from_two_vectors_core_checker import qftv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  logic      item_ready,
  input  qftv_in_t  item,
  input  logic      result_valid,
  input  logic      result_ready,
  input  qftv_out_t result,
  output int        fail_count,
  output int        pending
);

  qftv_out_t quat_q[$];
  int n_results;
  int n_opposite;
  int n_degen;

  // bitwise integer square root, floor
  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // shortest-arc quaternion of one vector pair
  function automatic qftv_out_t arc_quat(input qftv_in_t p, output bit opp);
    longint ux, uy, uz, vx, vy, vz, d, r;
    longint q[4];
    logic [63:0] uu, vv, n, big, total, m, o;
    logic [63:0] mg[4];
    int s;
    qftv_out_t res;
    ux = p.u_x; uy = p.u_y; uz = p.u_z;
    vx = p.v_x; vy = p.v_y; vz = p.v_z;
    opp = 0;
    uu = ux*ux + uy*uy + uz*uz;
    vv = vx*vx + vy*vy + vz*vz;
    res = '0;
    // zero vector gives identity
    if (uu == 0 || vv == 0) begin
      res.q_real = OUT_W'(1 << OUT_FRAC);
      res.degenerate = 1'b1;
      return res;
    end
    n = root_floor(uu * vv);
    d = ux*vx + uy*vy + uz*vz;
    r = longint'(n) + d;
    if (r < 0) r = 0;
    // opposite vectors: axis orthogonal to u
    if ((64'(r) << OPP_SHIFT) < n) begin
      opp = 1;
      q[0] = 0;
      if (mag(ux) > mag(uz)) begin
        q[1] = -uy; q[2] = ux; q[3] = 0;
      end else begin
        q[1] = 0; q[2] = -uz; q[3] = uy;
      end
    end else begin
      q[0] = r;
      q[1] = uy*vz - uz*vy;
      q[2] = uz*vx - ux*vz;
      q[3] = ux*vy - uy*vx;
    end
    // normalize
    big = 0;
    for (int i = 0; i < 4; i++) begin
      mg[i] = mag(q[i]);
      if (mg[i] > big) big = mg[i];
    end
    s = 0;
    while ((big >> s) >= (64'd1 << NORM_W)) s++;
    total = 0;
    for (int i = 0; i < 4; i++) begin
      mg[i] = mg[i] >> s;
      total += mg[i] * mg[i];
    end
    m = root_floor(total);
    if (m == 0) m = 1;
    for (int i = 0; i < 4; i++) begin
      o = ((mg[i] << OUT_FRAC) + (m >> 1)) / m;
      if (q[i] < 0) o = -o;
      case (i)
        0: res.q_real = o[OUT_W-1:0];
        1: res.q_i    = o[OUT_W-1:0];
        2: res.q_j    = o[OUT_W-1:0];
        default: res.q_k = o[OUT_W-1:0];
      endcase
    end
    return res;
  endfunction

  assign pending = quat_q.size();

  // predict on input beats, compare on result beats
  always @(posedge clk) begin
    qftv_out_t want;
    bit opp;
    if (rst) begin
      fail_count <= 0;
      n_results <= 0;
      n_opposite <= 0;
      n_degen <= 0;
    end else begin
      if (item_valid && item_ready) begin
        want = arc_quat(item, opp);
        quat_q.push_back(want);
        if (opp) n_opposite <= n_opposite + 1;
        if (want.degenerate) n_degen <= n_degen + 1;
      end
      if (result_valid && result_ready) begin
        n_results <= n_results + 1;
        if (quat_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = quat_q.pop_front();
          if (result !== want) begin
            if (result.q_real !== want.q_real)
              $error("q_real expected %0d got %0d", want.q_real, result.q_real);
            if (result.q_i !== want.q_i)
              $error("q_i expected %0d got %0d", want.q_i, result.q_i);
            if (result.q_j !== want.q_j)
              $error("q_j expected %0d got %0d", want.q_j, result.q_j);
            if (result.q_k !== want.q_k)
              $error("q_k expected %0d got %0d", want.q_k, result.q_k);
            if (result.degenerate !== want.degenerate)
              $error("degenerate expected %0b got %0b", want.degenerate,
                     result.degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/quaternion_from_two_vectors_core_tb.sv
// testbench top: vector pair stimulus, result back-pressure and verdict
`timescale 1ns / 1ps
module quaternion_from_two_vectors_core_tb;
  import qftv_pkg::*;

  localparam int LATENCY   = 89;
  localparam int N_RANDOM  = 2000;
  localparam int MAX_CYCLES = 400000;

  logic      clk = 0;
  logic      rst = 1;
  logic      item_valid = 0;
  logic      item_ready;
  qftv_in_t  item = '0;
  logic      result_valid;
  logic      result_ready = 0;
  qftv_out_t result;
  int        fail_count;
  int        pending;
  int        cycle_count = 0;
  bit        stim_done = 0;
  bit        long_hold = 0;
  qftv_in_t  pairs[$];

  quaternion_from_two_vectors_core i_dut (
    .clk, .rst, .item_valid, .item_ready, .item,
    .result_valid, .result_ready, .result
  );

  quaternion_from_two_vectors_core_checker i_checker (
    .clk, .rst, .item_valid, .item_ready, .item,
    .result_valid, .result_ready, .result, .fail_count, .pending
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // gap length: mostly short, sometimes long
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(3);
    return $urandom_range(40);
  endfunction

  function automatic logic signed [15:0] rnd_comp();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(7)) - 16'sd3;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic qftv_in_t mk(input int a, b, c, d, e, f);
    qftv_in_t p;
    p.u_x = IN_W'(a); p.u_y = IN_W'(b); p.u_z = IN_W'(c);
    p.v_x = IN_W'(d); p.v_y = IN_W'(e); p.v_z = IN_W'(f);
    return p;
  endfunction

  // build the directed and random pair list
  initial begin
    qftv_in_t p;
    int sc;
    pairs.push_back(mk(0, 0, 0, 256, 0, 0));
    pairs.push_back(mk(256, 0, 0, 0, 0, 0));
    pairs.push_back(mk(0, 0, 0, 0, 0, 0));
    pairs.push_back(mk(256, 0, 0, 256, 0, 0));
    pairs.push_back(mk(256, 0, 0, -256, 0, 0));
    pairs.push_back(mk(0, 0, 256, 0, 0, -512));
    pairs.push_back(mk(300, 7, 100, -600, -14, -200));
    pairs.push_back(mk(100, 7, 300, -200, -14, -600));
    pairs.push_back(mk(5, 5, 5, -5, -5, -5));
    pairs.push_back(mk(256, 0, 0, 0, 256, 0));
    pairs.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767));
    pairs.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768));
    pairs.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767));
    pairs.push_back(mk(32767, -32768, 1, -1, 32767, -32768));
    pairs.push_back(mk(1, 0, 0, 0, 0, 1));
    pairs.push_back(mk(1, 1, 0, 32767, 32767, 1));
    pairs.push_back(mk(-32768, 0, 0, 32767, 0, 0));
    pairs.push_back(mk(0, 3, 0, 0, -1, 0));
    pairs.push_back(mk(-1, -1, -1, 1, 2, 3));
    for (int i = 0; i < N_RANDOM; i++) begin
      p.u_x = rnd_comp(); p.u_y = rnd_comp(); p.u_z = rnd_comp();
      case ($urandom_range(9))
        // opposite pair with a scale
        0, 1: begin
          sc = $urandom_range(4, 1);
          p.v_x = IN_W'(-p.u_x / sc);
          p.v_y = IN_W'(-p.u_y / sc);
          p.v_z = IN_W'(-p.u_z / sc);
        end
        2: p = mk(0, 0, 0, rnd_comp(), rnd_comp(), rnd_comp());
        3: begin
          p.v_x = p.u_x; p.v_y = p.u_y; p.v_z = p.u_z;
        end
        default: begin
          p.v_x = rnd_comp(); p.v_y = rnd_comp(); p.v_z = rnd_comp();
        end
      endcase
      if ($urandom_range(30) == 0) begin
        p.v_x = '0; p.v_y = '0; p.v_z = '0;
      end
      pairs.push_back(p);
    end
  end

  // sender: valid drops during every gap so no beat is offered twice
  initial begin
    int g;
    int n_sent;
    n_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    while (pairs.size() > 0) begin
      item_valid <= 1;
      item <= pairs.pop_front();
      @(posedge clk);
      while (!item_ready) @(posedge clk);
      n_sent++;
      g = (n_sent < 200) ? 0 : gap_len();
      if (g > 0 || pairs.size() == 0) begin
        item_valid <= 0;
        repeat (g) @(posedge clk);
      end
    end
    item_valid <= 0;
    stim_done = 1;
  end

  // receiver: one long hold-off early on, then random stalls
  initial begin
    @(negedge rst);
    repeat (30) @(posedge clk);
    long_hold = 1;
    result_ready <= 0;
    repeat (300) @(posedge clk);
    long_hold = 0;
    forever begin
      if ($urandom_range(2) == 0) begin
        result_ready <= 0;
        repeat (gap_len() + 1) @(posedge clk);
      end
      result_ready <= 1;
      repeat ($urandom_range(20, 1)) @(posedge clk);
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("quaternion_from_two_vectors_core: mismatch");
      $finish;
    end
  end

  // verdict
  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("ran %0d vector pairs: %0d opposite, %0d degenerate, %0d results checked",
             i_checker.n_results, i_checker.n_opposite, i_checker.n_degen,
             i_checker.n_results);
    if (fail_count == 0 && pending == 0)
      $display("quaternion_from_two_vectors_core: match");
    else
      $display("quaternion_from_two_vectors_core: mismatch");
    $finish;
  end

endmodule
